@@ rtl/core/fhs_pkg.sv @@
// Shared types and constants of the feature bin histogram statistics block.
`default_nettype none

package fhs_pkg;

  // Default geometry of the histogram table
  localparam int FHS_FEATURES    = 64;
  localparam int FHS_BINS        = 256;
  localparam int FHS_QUEUE_DEPTH = 2;

  // Field widths fixed by the interface
  localparam int KIND_W    = 2;
  localparam int FEATURE_W = 6;
  localparam int BIN_W     = 8;
  localparam int TARGET_W  = 32;
  localparam int COUNT_W   = 32;
  localparam int SUM_W     = 64;
  localparam int SQUARE_W  = 63;
  localparam int CFG_W     = 9;

  localparam logic [CFG_W-1:0]    BINS_IN_USE_RESET = 9'd256;
  localparam logic [COUNT_W-1:0]  COUNT_MAX  = {COUNT_W{1'b1}};
  localparam logic [SQUARE_W-1:0] SQUARE_MAX = {SQUARE_W{1'b1}};
  localparam logic [SUM_W-1:0]    SUM_MAX    = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic [SUM_W-1:0]    SUM_MIN    = {1'b1, {(SUM_W-1){1'b0}}};

  // Command codes
  typedef enum logic [KIND_W-1:0] {
    KIND_ACCUM = 2'd0,
    KIND_READ  = 2'd1,
    KIND_CLEAR = 2'd2
  } kind_e;

  // Classified command handed from the front to the back
  typedef struct packed {
    kind_e                 op;
    logic                  in_range;
    logic [FEATURE_W-1:0]  feature;
    logic [BIN_W-1:0]      bin;
    logic [TARGET_W-1:0]   target;
  } cmd_t;

  // One table entry
  typedef struct packed {
    logic [COUNT_W-1:0]  count;
    logic [SUM_W-1:0]    sum;
    logic [SQUARE_W-1:0] square;
  } entry_t;

endpackage

`default_nettype wire

@@ rtl/core/fhs_front.sv @@
// Front end: command acceptance, range classification and the bin limit register.
`default_nettype none

module fhs_front #(
  parameter int FEATURES = 64,
  parameter int BINS     = 256
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           start_i,
  input  wire  [fhs_pkg::KIND_W-1:0]    kind_i,
  input  wire  [fhs_pkg::FEATURE_W-1:0] feature_i,
  input  wire  [fhs_pkg::BIN_W-1:0]     bin_i,
  input  wire  [fhs_pkg::TARGET_W-1:0]  target_i,
  input  wire                           cfg_we_i,
  input  wire  [fhs_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  wire                           queue_full_i,
  input  wire                           clearing_i,
  output logic                          busy_o,
  output logic                          push_o,
  output fhs_pkg::cmd_t                 cmd_o
);
  import fhs_pkg::*;

  logic [CFG_W-1:0] bins_q;
  logic             accept;
  logic             in_range;
  logic             keep;

  // Hold the bin limit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bins_q <= BINS_IN_USE_RESET;
    end else if (cfg_we_i) begin
      bins_q <= cfg_wdata_i;
    end
  end

  // Stall while the table is being cleared or the queue has no room
  assign busy_o = clearing_i | queue_full_i;
  assign accept = start_i & ~busy_o;

  assign in_range = (32'(feature_i) < FEATURES) && (32'(bin_i) < BINS) &&
                    ({1'b0, bin_i} < bins_q);

  // Drop commands that leave no trace; reads always produce a beat
  always_comb begin
    unique case (kind_i)
      KIND_READ:  keep = 1'b1;
      KIND_ACCUM,
      KIND_CLEAR: keep = in_range;
      default:    keep = 1'b0;
    endcase
  end

  assign push_o          = accept & keep;
  assign cmd_o.op        = kind_e'(kind_i);
  assign cmd_o.in_range  = in_range;
  assign cmd_o.feature   = feature_i;
  assign cmd_o.bin       = bin_i;
  assign cmd_o.target    = target_i;

endmodule

`default_nettype wire

@@ rtl/core/fhs_queue.sv @@
// Short command queue between the front and back ends.
`default_nettype none

module fhs_queue #(
  parameter int DEPTH = 2
) (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            push_i,
  input  fhs_pkg::cmd_t  cmd_i,
  input  wire            pop_i,
  output fhs_pkg::cmd_t  cmd_o,
  output logic           empty_o,
  output logic           full_o
);
  import fhs_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          slots_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] count_q;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == CW'(DEPTH));
  assign cmd_o   = slots_q[rd_ptr_q];

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // Store the pushed beat
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= cmd_i;
    end
  end

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("pop from empty queue");
  a_count_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> (count_q == $past(count_q) + 1'b1))
    else $error("queue occupancy did not grow on push");

endmodule

`default_nettype wire

@@ rtl/core/fhs_back.sv @@
// Back end: histogram table, clearing pass and saturating read-modify-write.
`default_nettype none

module fhs_back #(
  parameter int FEATURES = 64,
  parameter int BINS     = 256
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  empty_i,
  input  fhs_pkg::cmd_t                        cmd_i,
  output logic                                 pop_o,
  output logic                                 clearing_o,
  output logic                                 result_strobe_o,
  output logic        [fhs_pkg::COUNT_W-1:0]   hit_count_o,
  output logic signed [fhs_pkg::SUM_W-1:0]     target_sum_o,
  output logic        [fhs_pkg::SQUARE_W-1:0]  square_sum_o
);
  import fhs_pkg::*;

  localparam int DEPTH = FEATURES * BINS;
  localparam int AW    = $clog2(DEPTH);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  state_e                 state_q;
  cmd_t                   cmd_q;
  logic [AW-1:0]          addr_q;
  logic [AW-1:0]          rd_addr;
  logic [AW-1:0]          clr_idx_q;
  logic                   clearing_q;
  logic [47:0]            sq_q;
  logic [TARGET_W-1:0]    mag;
  logic [63:0]            prod;
  entry_t                 table_q [DEPTH];
  entry_t                 rdata_q;
  entry_t                 wr_data;
  logic                   wr_en;
  logic [SUM_W-1:0]       addend;
  logic [SUM_W-1:0]       sum_raw;
  logic                   sum_ovf;
  logic [63:0]            sq_raw;

  assign clearing_o = clearing_q;
  assign pop_o      = (state_q == S_IDLE) && !clearing_q && !empty_i;

  // Entry address of the command at the queue head
  assign rd_addr = cmd_i.in_range ?
                   AW'(32'(cmd_i.feature) * 32'(BINS) + 32'(cmd_i.bin)) : '0;

  // Square of the target magnitude, registered before the add
  assign mag  = cmd_i.target[TARGET_W-1] ? (~cmd_i.target + 1'b1) : cmd_i.target;
  assign prod = 64'(mag) * 64'(mag);

  // Saturating update of the fetched entry
  always_comb begin
    addend  = {{(SUM_W-TARGET_W){cmd_q.target[TARGET_W-1]}}, cmd_q.target};
    sum_raw = rdata_q.sum + addend;
    sum_ovf = (rdata_q.sum[SUM_W-1] == addend[SUM_W-1]) &&
              (sum_raw[SUM_W-1] != rdata_q.sum[SUM_W-1]);
    sq_raw  = {1'b0, rdata_q.square} + {16'd0, sq_q};
    wr_data = '0;
    wr_en   = 1'b0;
    if (state_q == S_EXEC && cmd_q.in_range) begin
      case (cmd_q.op)
        KIND_ACCUM: begin
          wr_en          = 1'b1;
          wr_data.count  = (rdata_q.count == COUNT_MAX) ? COUNT_MAX
                                                        : rdata_q.count + 1'b1;
          wr_data.sum    = sum_ovf ? (rdata_q.sum[SUM_W-1] ? SUM_MIN : SUM_MAX)
                                   : sum_raw;
          wr_data.square = sq_raw[63] ? SQUARE_MAX : sq_raw[SQUARE_W-1:0];
        end
        KIND_CLEAR: begin
          wr_en = 1'b1;
        end
        default: begin
          wr_en = 1'b0;
        end
      endcase
    end
  end

  // Sequence commands, sweep the table after reset, drive result beats
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_IDLE;
      clearing_q      <= 1'b1;
      clr_idx_q       <= '0;
      cmd_q           <= '0;
      addr_q          <= '0;
      sq_q            <= '0;
      result_strobe_o <= 1'b0;
      hit_count_o     <= '0;
      target_sum_o    <= '0;
      square_sum_o    <= '0;
    end else begin
      result_strobe_o <= 1'b0;
      if (clearing_q) begin
        if (clr_idx_q == AW'(DEPTH - 1)) begin
          clearing_q <= 1'b0;
        end else begin
          clr_idx_q <= clr_idx_q + 1'b1;
        end
      end
      unique case (state_q)
        S_IDLE: begin
          if (pop_o) begin
            cmd_q   <= cmd_i;
            addr_q  <= rd_addr;
            sq_q    <= prod[63:16];
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (cmd_q.op == KIND_READ) begin
            result_strobe_o <= 1'b1;
            if (cmd_q.in_range) begin
              hit_count_o  <= rdata_q.count;
              target_sum_o <= rdata_q.sum;
              square_sum_o <= rdata_q.square;
            end else begin
              hit_count_o  <= '0;
              target_sum_o <= '0;
              square_sum_o <= '0;
            end
          end
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Table: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (clearing_q) begin
      table_q[clr_idx_q] <= '0;
    end else if (wr_en) begin
      table_q[addr_q] <= wr_data;
    end
    if (pop_o) begin
      rdata_q <= table_q[rd_addr];
    end
  end

  a_strobe_after_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o |-> $past(state_q == S_EXEC))
    else $error("result beat without an executed read");
  a_idle_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing_q |-> (state_q == S_IDLE))
    else $error("command executed during clearing pass");

endmodule

`default_nettype wire

@@ rtl/core/feature_bin_histogram_stats.sv @@
// Top level of the feature bin histogram statistics block.
//
// Usage: present a command on kind_i, feature_i, bin_i and target_i with
// start_i high; it is taken at the rising edge where busy_o is low. Kinds:
// accumulate a Q16.16 target into one entry, read one entry, clear one entry.
// A read delivers one beat on hit_count_o, target_sum_o and square_sum_o,
// marked by result_strobe_o for exactly one cycle; the receiver must take it.
// Accumulate, clear and unused kinds deliver nothing.
// Path: an accepted read passes through a queue slot, the back end's fetch
// register and the result registers. The back end fetches then writes each
// entry and takes the next command only once back in idle; a two-deep queue
// lets the front take commands while the back is still working.
// Reset: busy_o stays high for a clearing pass that zeroes every one of the
// FEATURES*BINS entries (16384 at the defaults); cfg_we_i writes of
// bins_in_use are taken at any time and reset sets it to 256.
`default_nettype none

module feature_bin_histogram_stats #(
  parameter int FEATURES    = fhs_pkg::FHS_FEATURES,
  parameter int BINS        = fhs_pkg::FHS_BINS,
  parameter int QUEUE_DEPTH = fhs_pkg::FHS_QUEUE_DEPTH
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  start_i,
  output logic                                 busy_o,
  input  wire         [fhs_pkg::KIND_W-1:0]    kind_i,
  input  wire         [fhs_pkg::FEATURE_W-1:0] feature_i,
  input  wire         [fhs_pkg::BIN_W-1:0]     bin_i,
  input  wire  signed [fhs_pkg::TARGET_W-1:0]  target_i,
  input  wire                                  cfg_we_i,
  input  wire         [fhs_pkg::CFG_W-1:0]     cfg_wdata_i,
  output logic                                 result_strobe_o,
  output logic        [fhs_pkg::COUNT_W-1:0]   hit_count_o,
  output logic signed [fhs_pkg::SUM_W-1:0]     target_sum_o,
  output logic        [fhs_pkg::SQUARE_W-1:0]  square_sum_o
);
  import fhs_pkg::*;

  logic push, pop, q_empty, q_full, clearing;
  cmd_t push_cmd, head_cmd;

  fhs_front #(
    .FEATURES (FEATURES),
    .BINS     (BINS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .kind_i       (kind_i),
    .feature_i    (feature_i),
    .bin_i        (bin_i),
    .target_i     (target_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .queue_full_i (q_full),
    .clearing_i   (clearing),
    .busy_o       (busy_o),
    .push_o       (push),
    .cmd_o        (push_cmd)
  );

  fhs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .pop_i   (pop),
    .cmd_o   (head_cmd),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  fhs_back #(
    .FEATURES (FEATURES),
    .BINS     (BINS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .empty_i         (q_empty),
    .cmd_i           (head_cmd),
    .pop_o           (pop),
    .clearing_o      (clearing),
    .result_strobe_o (result_strobe_o),
    .hit_count_o     (hit_count_o),
    .target_sum_o    (target_sum_o),
    .square_sum_o    (square_sum_o)
  );

  a_busy_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> (busy_o && q_empty))
    else $error("command queued during clearing pass");

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
// Self-checking testbench for the feature bin histogram statistics block.
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import fhs_pkg::*;

  // Code with no command behind it; the block must ignore it
  localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;
  // Accumulates of the most negative target piled onto one entry
  localparam int EXTREME_RUN = 16;

  // Mirror of the histogram table plus the reads still waiting for their beat
  class hist_scoreboard;
    entry_t             entry_tab [int];
    entry_t             read_queue [$];
    logic [CFG_W-1:0]   bins_limit;
    int                 errors;

    function new();
      bins_limit = BINS_IN_USE_RESET;
      errors     = 0;
    endfunction

    function void set_bins(logic [CFG_W-1:0] v);
      bins_limit = v;
    endfunction

    function int pending();
      return read_queue.size();
    endfunction

    // Apply one accepted command to the mirror; a read queues its expected beat
    function void note_command(logic [KIND_W-1:0] k, logic [FEATURE_W-1:0] f,
                               logic [BIN_W-1:0] b, logic [TARGET_W-1:0] t);
      int                  idx;
      logic                hit;
      entry_t              e;
      logic signed [64:0]  wide_sum;
      logic [31:0]         mag;
      logic [63:0]         sq_full;
      logic [63:0]         sq_total;
      idx = int'({f, b});
      hit = ({1'b0, b} < bins_limit);
      e   = '0;
      if (hit && entry_tab.exists(idx)) e = entry_tab[idx];
      case (k)
        KIND_ACCUM: begin
          if (hit) begin
            if (e.count != COUNT_MAX) e.count = e.count + 1'b1;
            // clamp the target sum on signed overflow
            wide_sum = $signed({e.sum[63], e.sum}) + $signed({{33{t[31]}}, t});
            if (wide_sum[64] != wide_sum[63]) e.sum = wide_sum[64] ? SUM_MIN : SUM_MAX;
            else e.sum = wide_sum[63:0];
            // square of the magnitude, back to Q16.16, clamped at the top
            mag      = t[31] ? (~t + 32'd1) : t;
            sq_full  = {32'd0, mag} * {32'd0, mag};
            sq_total = {1'b0, e.square} + (sq_full >> 16);
            e.square = sq_total[63] ? SQUARE_MAX : sq_total[62:0];
            entry_tab[idx] = e;
          end
        end
        KIND_READ: read_queue.push_back(hit ? e : entry_t'('0));
        KIND_CLEAR: begin
          if (hit) entry_tab.delete(idx);
        end
        default: ;
      endcase
    endfunction

    // Compare one result beat with the oldest outstanding read
    function void check_result(logic [COUNT_W-1:0] cnt, logic [SUM_W-1:0] sum,
                               logic [SQUARE_W-1:0] sq);
      entry_t want;
      if (read_queue.size() == 0) begin
        errors++;
        $display("%0t: beat with no read outstanding: count %h sum %h square %h",
                 $time, cnt, sum, sq);
        return;
      end
      want = read_queue.pop_front();
      if (cnt !== want.count) begin
        errors++;
        $display("%0t: hit_count expected %h actual %h", $time, want.count, cnt);
      end
      if (sum !== want.sum) begin
        errors++;
        $display("%0t: target_sum expected %h actual %h", $time, want.sum, sum);
      end
      if (sq !== want.square) begin
        errors++;
        $display("%0t: square_sum expected %h actual %h", $time, want.square, sq);
      end
    endfunction
  endclass

  logic                        clk_i       = 1'b0;
  logic                        rst_ni      = 1'b0;
  logic                        start_i     = 1'b0;
  logic [KIND_W-1:0]           kind_i      = '0;
  logic [FEATURE_W-1:0]        feature_i   = '0;
  logic [BIN_W-1:0]            bin_i       = '0;
  logic signed [TARGET_W-1:0]  target_i    = '0;
  logic                        cfg_we_i    = 1'b0;
  logic [CFG_W-1:0]            cfg_wdata_i = '0;
  logic                        busy_o;
  logic                        result_strobe_o;
  logic [COUNT_W-1:0]          hit_count_o;
  logic signed [SUM_W-1:0]     target_sum_o;
  logic [SQUARE_W-1:0]         square_sum_o;

  hist_scoreboard sb = new();
  bit             no_gaps  = 1'b0;
  int             cur_bins = 256;

  feature_bin_histogram_stats uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .kind_i          (kind_i),
    .feature_i       (feature_i),
    .bin_i           (bin_i),
    .target_i        (target_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .result_strobe_o (result_strobe_o),
    .hit_count_o     (hit_count_o),
    .target_sum_o    (target_sum_o),
    .square_sum_o    (square_sum_o)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Check every result beat on the edge that ends it
  always @(posedge clk_i) begin
    if (rst_ni && result_strobe_o) sb.check_result(hit_count_o, target_sum_o, square_sum_o);
  end

  // Present one command, after a random gap unless no_gaps is set, and hold it until the handshake
  task automatic drive_cmd(input logic [KIND_W-1:0] k, input logic [FEATURE_W-1:0] f,
                           input logic [BIN_W-1:0] b, input logic [TARGET_W-1:0] t);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i   <= 1'b1;
    kind_i    <= k;
    feature_i <= f;
    bin_i     <= b;
    target_i  <= t;
    do @(posedge clk_i); while (busy_o);
    sb.note_command(k, f, b, t);
  endtask

  // Hold off the sender until every read beat is back, then idle a while
  task automatic drain_results(input int extra);
    start_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
    repeat (extra) @(posedge clk_i);
  endtask

  // Write bins_in_use with the block idle
  task automatic put_cfg(input logic [CFG_W-1:0] v);
    drain_results(12);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    sb.set_bins(v);
    cur_bins = int'(v);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [TARGET_W-1:0] pick_target();
    case ($urandom_range(0, 5))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'hFFFF_FFFF;
      3:       return $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
      default: return $urandom;
    endcase
  endfunction

  // One random command, biased toward a few entries so reads see history
  task automatic random_cmd();
    logic [KIND_W-1:0]    k;
    logic [FEATURE_W-1:0] f;
    logic [BIN_W-1:0]     b;
    int                   r;
    int                   hi;
    r = $urandom_range(0, 99);
    if (r < 50)      k = KIND_ACCUM;
    else if (r < 80) k = KIND_READ;
    else if (r < 90) k = KIND_CLEAR;
    else             k = KIND_NONE;
    f  = ($urandom_range(0, 7) == 0) ? FEATURE_W'($urandom) : FEATURE_W'($urandom_range(0, 3));
    hi = (cur_bins > 256) ? 256 : cur_bins;
    r  = $urandom_range(0, 7);
    if (hi == 0 || r == 0) b = BIN_W'($urandom);
    else if (r == 1)       b = BIN_W'(hi - 1);
    else                   b = BIN_W'($urandom_range(0, ((hi < 6) ? hi : 6) - 1));
    drive_cmd(k, f, b, pick_target());
  endtask

  initial begin
    logic [CFG_W-1:0] chunk_bins [7];
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: table cleared by reset, target extremes, unused kind
    drive_cmd(KIND_READ, 6'd0, 8'd0, 32'd0);
    drive_cmd(KIND_READ, 6'd63, 8'd255, 32'd0);
    drive_cmd(KIND_ACCUM, 6'd0, 8'd0, 32'h7FFF_FFFF);
    drive_cmd(KIND_ACCUM, 6'd0, 8'd0, 32'h8000_0000);
    drive_cmd(KIND_ACCUM, 6'd0, 8'd0, 32'd0);
    drive_cmd(KIND_READ, 6'd0, 8'd0, 32'd0);
    drive_cmd(KIND_ACCUM, 6'd63, 8'd255, 32'hFFFF_FFFF);
    drive_cmd(KIND_ACCUM, 6'd63, 8'd255, 32'h0001_0000);
    drive_cmd(KIND_READ, 6'd63, 8'd255, 32'd0);
    drive_cmd(KIND_CLEAR, 6'd0, 8'd0, 32'd0);
    drive_cmd(KIND_READ, 6'd0, 8'd0, 32'd0);
    drive_cmd(KIND_NONE, 6'd63, 8'd255, 32'h5A5A_A5A5);
    drive_cmd(KIND_READ, 6'd63, 8'd255, 32'd0);

    // Directed: one bin in use, bins above it ignored
    put_cfg(9'd1);
    drive_cmd(KIND_ACCUM, 6'd1, 8'd1, 32'h0002_0000);
    drive_cmd(KIND_ACCUM, 6'd1, 8'd0, 32'hFFFE_0000);
    drive_cmd(KIND_READ, 6'd1, 8'd1, 32'd0);
    drive_cmd(KIND_CLEAR, 6'd1, 8'd1, 32'd0);
    drive_cmd(KIND_READ, 6'd1, 8'd0, 32'd0);

    // Directed: no bin in use, then every bin in use
    put_cfg(9'd0);
    drive_cmd(KIND_ACCUM, 6'd2, 8'd0, 32'h0001_0000);
    drive_cmd(KIND_READ, 6'd2, 8'd0, 32'd0);
    put_cfg(9'd511);
    drive_cmd(KIND_ACCUM, 6'd3, 8'd255, 32'h8000_0000);
    drive_cmd(KIND_READ, 6'd3, 8'd255, 32'd0);

    // Random commands over a spread of bin limits
    chunk_bins[0] = 9'd1;
    chunk_bins[1] = 9'd255;
    chunk_bins[2] = 9'd511;
    chunk_bins[3] = CFG_W'($urandom_range(2, 256));
    chunk_bins[4] = 9'd256;
    chunk_bins[5] = CFG_W'($urandom_range(1, 256));
    chunk_bins[6] = 9'd2;
    foreach (chunk_bins[c]) begin
      put_cfg(chunk_bins[c]);
      no_gaps = ($urandom_range(0, 3) == 0);
      repeat (130) begin
        if ($urandom_range(0, 63) == 0) drain_results(0);
        random_cmd();
      end
    end

    // Pile extreme targets onto one entry back to back, then check it reads and clears
    put_cfg(9'd256);
    no_gaps = 1'b1;
    drive_cmd(KIND_CLEAR, 6'd5, 8'd3, 32'd0);
    repeat (EXTREME_RUN) drive_cmd(KIND_ACCUM, 6'd5, 8'd3, 32'h8000_0000);
    drive_cmd(KIND_READ, 6'd5, 8'd3, 32'd0);
    drive_cmd(KIND_ACCUM, 6'd5, 8'd3, 32'h7FFF_FFFF);
    drive_cmd(KIND_READ, 6'd5, 8'd3, 32'd0);
    drive_cmd(KIND_CLEAR, 6'd5, 8'd3, 32'd0);
    drive_cmd(KIND_READ, 6'd5, 8'd3, 32'd0);

    drain_results(20);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog well beyond the slowest legal run
  initial begin
    #20_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

`default_nettype wire

@@ files.f @@
rtl/core/fhs_pkg.sv
rtl/core/fhs_front.sv
rtl/core/fhs_queue.sv
rtl/core/fhs_back.sv
rtl/core/feature_bin_histogram_stats.sv
tb/tb_top.sv
